// File: src/cwr_pkg.sv
// cwr_pkg: shared types and constants of the chunked write reassembler
// no dependencies; used by cwr_buf, the core and the checker
`timescale 1ns / 1ps

package cwr_pkg;

  localparam int unsigned BEAT_BYTES     = 4;
  localparam int unsigned HELD_W         = 8;
  localparam int unsigned FLAG_START_BIT = 0;
  localparam int unsigned FLAG_END_BIT   = 1;
  localparam logic [15:0] TIMEOUT_RESET  = 16'd1000;
  localparam logic        KIND_REPORT    = 1'b0;
  localparam logic        KIND_BEAT      = 1'b1;

  typedef struct packed {
    logic [7:0]  dev_addr;
    logic [7:0]  chunk_flags;
    logic [7:0]  data_len;
    logic [2:0]  avail_len;
    logic [7:0]  payload_byte0;
    logic [7:0]  payload_byte1;
    logic [7:0]  payload_byte2;
    logic [7:0]  payload_byte3;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] target_addr;
    logic [7:0] echo_flags;
    logic [7:0] byte_count;
    logic       success;
    logic [7:0] data_byte0;
    logic [7:0] data_byte1;
    logic [7:0] data_byte2;
    logic [7:0] data_byte3;
    logic [2:0] beat_bytes;
    logic       last;
  } result_t;

  typedef struct packed {
    logic                                en;
    logic [HELD_W-1:0]                   base;
    logic [2:0]                          len;
    logic [BEAT_BYTES-1:0][7:0]          data;
  } buf_wr_t;

  function automatic result_t make_report(logic [7:0] addr, logic [7:0] flags,
                                          logic [7:0] held, logic ok, logic last_f);
    result_t r;
    r             = '0;
    r.result_kind = KIND_REPORT;
    r.target_addr = addr;
    r.echo_flags  = flags;
    r.byte_count  = held;
    r.success     = ok;
    r.last        = last_f;
    return r;
  endfunction

endpackage

// File: src/cwr_ram.sv
// cwr_ram: generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module cwr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 34
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: src/cwr_buf.sv
// cwr_buf: session buffer as four byte lanes, unaligned chunk write, row read
// depends on cwr_pkg and cwr_ram
`timescale 1ns / 1ps

module cwr_buf #(
  parameter int unsigned BUFFER_BYTES = 136
) (
  input  logic                     clk_i,
  input  cwr_pkg::buf_wr_t         wr_i,
  input  logic                     rd_en_i,
  input  logic [(((BUFFER_BYTES + cwr_pkg::BEAT_BYTES - 1) / cwr_pkg::BEAT_BYTES) > 1 ?
                 $clog2((BUFFER_BYTES + cwr_pkg::BEAT_BYTES - 1) / cwr_pkg::BEAT_BYTES) : 1)-1:0]
                                   rd_row_i,
  output logic [cwr_pkg::BEAT_BYTES-1:0][7:0] rd_data_o
);

  localparam int unsigned ROWS  = (BUFFER_BYTES + cwr_pkg::BEAT_BYTES - 1) / cwr_pkg::BEAT_BYTES;
  localparam int unsigned ROW_W = ROWS > 1 ? $clog2(ROWS) : 1;

  for (genvar l = 0; l < cwr_pkg::BEAT_BYTES; l++) begin : g_lane
    logic [1:0] off;
    logic       en;
    logic [5:0] row6;

    assign off  = 2'(l) - wr_i.base[1:0];
    assign en   = wr_i.en && ({1'b0, off} < wr_i.len);
    assign row6 = wr_i.base[7:2] + {5'b0, (2'(l) < wr_i.base[1:0])};

    cwr_ram #(
      .WIDTH(8),
      .DEPTH(ROWS)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (en),
      .waddr_i(row6[ROW_W-1:0]),
      .wdata_i(wr_i.data[off]),
      .re_i   (rd_en_i),
      .raddr_i(rd_row_i),
      .rdata_o(rd_data_o[l])
    );
  end

endmodule

// File: src/chunked_write_reassembler_core.sv
// chunked_write_reassembler_core: session control and result sequencing
// depends on cwr_pkg and cwr_buf
//
//  channel   | handshake              | word
//  ----------+------------------------+-------------------------------
//  chunk in  | start / busy           | item_i   (cwr_pkg::item_t)
//  result    | result_valid_o strobe  | result_o (cwr_pkg::result_t)
//  config    | cfg_we_i               | cfg_wdata_i (timeout_ms)
//
// a chunk passes S_CHECK and S_EVAL; an end chunk then passes S_RD, S_BEAT and S_DONE,
// with S_BEAT giving one beat per cycle as the lane rams are read row by row
// reset clears the session and loads the timeout with 1000; buffer is not cleared
// results go out one per cycle and cannot be held off by the receiver
`timescale 1ns / 1ps

module chunked_write_reassembler_core #(
  parameter int unsigned BUFFER_BYTES = 136,
  parameter int unsigned CHUNK_MAX    = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  cwr_pkg::item_t   item_i,
  output logic             result_valid_o,
  output cwr_pkg::result_t result_o,
  input  logic             cfg_we_i,
  input  logic [15:0]      cfg_wdata_i
);

  localparam int unsigned ROWS  = (BUFFER_BYTES + cwr_pkg::BEAT_BYTES - 1) / cwr_pkg::BEAT_BYTES;
  localparam int unsigned ROW_W = ROWS > 1 ? $clog2(ROWS) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_EVAL,
    S_RD,
    S_BEAT,
    S_DONE
  } state_e;

  state_e           state_q;
  cwr_pkg::item_t   item_q;
  cwr_pkg::result_t result_q;
  logic             valid_q;
  logic [15:0]      timeout_q;
  logic             open_q;
  logic [7:0]       addr_q;
  logic [7:0]       held_q;
  logic [31:0]      last_q;
  logic [ROW_W-1:0] row_q;
  logic [7:0]       rem_q;

  logic [2:0]       avail_c;
  logic             len_bad;
  logic             start_f;
  logic             end_f;
  logic             eff_open;
  logic [7:0]       eff_addr;
  logic [7:0]       eff_held;
  logic             match;
  logic [8:0]       sum9;
  logic             over;
  logic             ok_write;
  logic [31:0]      idle_ms;
  logic             timed_out;
  logic [2:0]       cnt;
  logic             rd_en;
  cwr_pkg::buf_wr_t wr;
  logic [cwr_pkg::BEAT_BYTES-1:0][7:0] rd_data;
  cwr_pkg::result_t beat;

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = valid_q;
  assign result_o       = result_q;

  always_comb begin
    avail_c   = (item_q.avail_len > 3'(cwr_pkg::BEAT_BYTES)) ? 3'(cwr_pkg::BEAT_BYTES)
                                                             : item_q.avail_len;
    len_bad   = (item_q.data_len == 8'd0) || (item_q.data_len > 8'(CHUNK_MAX)) ||
                ({5'b0, avail_c} < item_q.data_len);
    start_f   = item_q.chunk_flags[cwr_pkg::FLAG_START_BIT];
    end_f     = item_q.chunk_flags[cwr_pkg::FLAG_END_BIT];
    eff_open  = start_f || open_q;
    eff_addr  = start_f ? item_q.dev_addr : addr_q;
    eff_held  = start_f ? 8'd0 : held_q;
    match     = eff_open && (eff_addr == item_q.dev_addr);
    sum9      = {1'b0, eff_held} + {1'b0, item_q.data_len};
    over      = sum9 > 9'(BUFFER_BYTES);
    ok_write  = !len_bad && match && !over;
    idle_ms   = item_q.now_ms - last_q;
    timed_out = open_q && (idle_ms > {16'b0, timeout_q});
    cnt       = (rem_q > 8'(cwr_pkg::BEAT_BYTES)) ? 3'(cwr_pkg::BEAT_BYTES) : rem_q[2:0];
    rd_en     = (state_q == S_RD) ||
                ((state_q == S_BEAT) && (rem_q > 8'(cwr_pkg::BEAT_BYTES)));
  end

  always_comb begin
    wr.en   = (state_q == S_EVAL) && ok_write;
    wr.base = eff_held;
    wr.len  = item_q.data_len[2:0];
    wr.data = {item_q.payload_byte3, item_q.payload_byte2,
               item_q.payload_byte1, item_q.payload_byte0};
  end

  // write beat from the lane read data, bytes past the count read as zero
  always_comb begin
    beat             = '0;
    beat.result_kind = cwr_pkg::KIND_BEAT;
    beat.target_addr = addr_q;
    beat.echo_flags  = item_q.chunk_flags;
    beat.byte_count  = held_q;
    beat.success     = 1'b1;
    beat.data_byte0  = (cnt > 3'd0) ? rd_data[0] : 8'd0;
    beat.data_byte1  = (cnt > 3'd1) ? rd_data[1] : 8'd0;
    beat.data_byte2  = (cnt > 3'd2) ? rd_data[2] : 8'd0;
    beat.data_byte3  = (cnt > 3'd3) ? rd_data[3] : 8'd0;
    beat.beat_bytes  = cnt;
  end

  cwr_buf #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_buf (
    .clk_i    (clk_i),
    .wr_i     (wr),
    .rd_en_i  (rd_en),
    .rd_row_i (row_q),
    .rd_data_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      item_q    <= '0;
      result_q  <= '0;
      valid_q   <= 1'b0;
      timeout_q <= cwr_pkg::TIMEOUT_RESET;
      open_q    <= 1'b0;
      addr_q    <= 8'd0;
      held_q    <= 8'd0;
      last_q    <= 32'd0;
      row_q     <= '0;
      rem_q     <= 8'd0;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      unique case (state_q)
        S_IDLE: begin
          valid_q <= 1'b0;
          if (start) begin
            item_q  <= item_i;
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          valid_q <= timed_out;
          if (timed_out) begin
            result_q <= cwr_pkg::make_report(addr_q, 8'd0, held_q, 1'b0, 1'b0);
            open_q   <= 1'b0;
            addr_q   <= 8'd0;
            held_q   <= 8'd0;
            last_q   <= 32'd0;
          end
          state_q <= S_EVAL;
        end
        S_EVAL: begin
          if (len_bad) begin
            result_q <= cwr_pkg::make_report(item_q.dev_addr, item_q.chunk_flags,
                                             held_q, 1'b0, 1'b1);
            valid_q  <= 1'b1;
            state_q  <= S_IDLE;
          end else if (!match) begin
            result_q <= cwr_pkg::make_report(item_q.dev_addr, item_q.chunk_flags,
                                             eff_held, 1'b0, 1'b1);
            valid_q  <= 1'b1;
            state_q  <= S_IDLE;
          end else if (over) begin
            result_q <= cwr_pkg::make_report(item_q.dev_addr, item_q.chunk_flags,
                                             eff_held, 1'b0, 1'b1);
            valid_q  <= 1'b1;
            open_q   <= 1'b0;
            addr_q   <= 8'd0;
            held_q   <= 8'd0;
            last_q   <= 32'd0;
            state_q  <= S_IDLE;
          end else begin
            open_q <= 1'b1;
            addr_q <= eff_addr;
            held_q <= sum9[7:0];
            last_q <= item_q.now_ms;
            if (end_f) begin
              valid_q <= 1'b0;
              row_q   <= '0;
              state_q <= S_RD;
            end else begin
              result_q <= cwr_pkg::make_report(item_q.dev_addr, item_q.chunk_flags,
                                               sum9[7:0], 1'b1, 1'b1);
              valid_q  <= 1'b1;
              state_q  <= S_IDLE;
            end
          end
        end
        S_RD: begin
          valid_q <= 1'b0;
          row_q   <= ROW_W'(row_q + 1'b1);
          rem_q   <= held_q;
          state_q <= S_BEAT;
        end
        S_BEAT: begin
          result_q <= beat;
          valid_q  <= 1'b1;
          rem_q    <= rem_q - {5'b0, cnt};
          if (rem_q > 8'(cwr_pkg::BEAT_BYTES)) begin
            row_q <= ROW_W'(row_q + 1'b1);
          end else begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          result_q <= cwr_pkg::make_report(item_q.dev_addr, item_q.chunk_flags,
                                           held_q, (held_q != 8'd0), 1'b1);
          valid_q  <= 1'b1;
          open_q   <= 1'b0;
          addr_q   <= 8'd0;
          held_q   <= 8'd0;
          last_q   <= 32'd0;
          state_q  <= S_IDLE;
        end
        default: begin
          valid_q <= 1'b0;
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: src/cwr_checker.sv
// cwr_checker: port level assertions for the reassembler, bound to the top level
// depends on cwr_pkg and chunked_write_reassembler_core
`timescale 1ns / 1ps

module cwr_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             result_valid_o,
  input cwr_pkg::result_t result_o
);

  // accepted word makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted word did not make the block busy");

  // the block goes idle exactly with the final result
  a_fell_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> (result_valid_o && result_o.last))
    else $error("block went idle without a final result");

  a_notlast_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.last) |-> busy)
    else $error("intermediate result while idle");

  a_beat_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (result_o.result_kind == cwr_pkg::KIND_BEAT)) |->
    (result_o.success && !result_o.last && (result_o.beat_bytes != 3'd0) &&
     (result_o.beat_bytes <= 3'(cwr_pkg::BEAT_BYTES))))
    else $error("malformed write beat");

  a_report_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (result_o.result_kind == cwr_pkg::KIND_REPORT)) |->
    ((result_o.beat_bytes == 3'd0) && (result_o.data_byte0 == 8'd0) &&
     (result_o.data_byte3 == 8'd0)))
    else $error("report carries data");

endmodule

bind chunked_write_reassembler_core cwr_checker u_cwr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .result_valid_o(result_valid_o),
  .result_o      (result_o)
);
